// ===== hdl/tvtf_pkg.sv =====
// Shared types, constants and helpers of the trajectory velocity time fix block.
package tvtf_pkg;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int JOINTS = 7;
  localparam int LARGE_JOINTS_DEFAULT = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int ADDR_W = 4;

  localparam logic [DATA_W-1:0] LARGE_VEL_LIMIT_RESET = 32'd41157;
  localparam logic [DATA_W-1:0] LARGE_VEL_RECIP_RESET = 32'd104335;
  localparam logic [DATA_W-1:0] SMALL_VEL_LIMIT_RESET = 32'd54919;
  localparam logic [DATA_W-1:0] SMALL_VEL_RECIP_RESET = 32'd78196;

  typedef enum logic [1:0] {
    REG_LARGE_VEL_LIMIT = 2'd0,
    REG_LARGE_VEL_RECIP = 2'd1,
    REG_SMALL_VEL_LIMIT = 2'd2,
    REG_SMALL_VEL_RECIP = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [31:0]        point_time;
    logic signed [31:0] pos_0;
    logic signed [31:0] pos_1;
    logic signed [31:0] pos_2;
    logic signed [31:0] pos_3;
    logic signed [31:0] pos_4;
    logic signed [31:0] pos_5;
    logic signed [31:0] pos_6;
    logic               first_point;
    logic               last_point;
  } point_t;

  typedef struct packed {
    logic [31:0] fixed_time;
    logic        was_corrected;
    logic        is_last;
  } result_t;

  typedef struct packed {
    logic [DATA_W-1:0] large_vel_limit;
    logic [DATA_W-1:0] large_vel_recip;
    logic [DATA_W-1:0] small_vel_limit;
    logic [DATA_W-1:0] small_vel_recip;
  } cfg_t;

  // One classified segment as it travels from the front end to the back end.
  typedef struct packed {
    logic [JOINTS-1:0][DATA_W-1:0] mag;
    logic [DATA_W-1:0]             planned;
    logic                          planned_pos;
    logic                          first;
    logic                          last;
    logic [DATA_W-1:0]             point_time;
  } seg_t;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

endpackage

// ===== hdl/tvtf_front.sv =====
// Front end: accepts points, keeps the previous point and forms joint deltas.
module tvtf_front import tvtf_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   point_valid,
  output logic   point_stall,
  input  point_t point,
  input  logic   queue_full,
  output logic   push,
  output seg_t   seg
);

  logic [JOINTS-1:0][DATA_W-1:0] cur;
  logic [JOINTS-1:0][DATA_W-1:0] prev_pos;
  logic [DATA_W-1:0]             prev_time;

  assign cur[0] = point.pos_0;
  assign cur[1] = point.pos_1;
  assign cur[2] = point.pos_2;
  assign cur[3] = point.pos_3;
  assign cur[4] = point.pos_4;
  assign cur[5] = point.pos_5;
  assign cur[6] = point.pos_6;

  assign point_stall = queue_full;
  assign push        = point_valid && !queue_full;

  for (genvar j = 0; j < JOINTS; j++) begin : g_delta
    logic signed [DATA_W:0] diff;
    logic signed [DATA_W:0] neg;
    assign diff = $signed({cur[j][DATA_W-1], cur[j]})
                - $signed({prev_pos[j][DATA_W-1], prev_pos[j]});
    assign neg  = -diff;
    // The magnitude of a 33-bit difference of two 32-bit values fits 32 bits.
    assign seg.mag[j] = diff[DATA_W] ? neg[DATA_W-1:0] : diff[DATA_W-1:0];
  end

  assign seg.planned_pos = point.point_time > prev_time;
  assign seg.planned     = point.point_time - prev_time;
  assign seg.first       = point.first_point;
  assign seg.last        = point.last_point;
  assign seg.point_time  = point.point_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      prev_pos  <= '0;
    end else if (push) begin
      prev_time <= point.point_time;
      prev_pos  <= cur;
    end
  end

endmodule

// ===== hdl/tvtf_queue.sv =====
// Short queue of classified segments between the front end and the back end.
module tvtf_queue import tvtf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  seg_t wr_seg,
  input  logic pop,
  output seg_t head,
  output logic empty,
  output logic full
);

  // DEPTH must be at least two.
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  seg_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = count == '0;
  assign full  = count == CNT_W'(DEPTH);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue holds more entries than its depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not drop after a pop");
`endif

endmodule

// ===== hdl/tvtf_back.sv =====
// Back end: per-joint minimum time and limit test, maximum, correction and output.
module tvtf_back import tvtf_pkg::*; #(
  parameter int LARGE_JOINTS = LARGE_JOINTS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  seg_t    head,
  input  logic    queue_empty,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic en;

  logic [JOINTS-1:0][DATA_W-1:0] recip_sel;
  logic [JOINTS-1:0][DATA_W-1:0] limit_sel;

  // Stage 1: products.
  logic                          s1_valid;
  logic [JOINTS-1:0][PROD_W-1:0] s1_mt_prod;
  logic [JOINTS-1:0][PROD_W-1:0] s1_lim_prod;
  logic [JOINTS-1:0][DATA_W-1:0] s1_mag;
  logic                          s1_pos;
  logic                          s1_first;
  logic                          s1_last;
  logic [DATA_W-1:0]             s1_time;

  // Stage 2: saturated minimum times and limit test per joint.
  logic                          s2_valid;
  logic [JOINTS-1:0][DATA_W-1:0] s2_mt;
  logic [JOINTS-1:0]             s2_exceed;
  logic                          s2_pos;
  logic                          s2_first;
  logic                          s2_last;
  logic [DATA_W-1:0]             s2_time;

  // Stage 3: segment maximum and verdict.
  logic              s3_valid;
  logic [DATA_W-1:0] s3_max;
  logic              s3_invalid;
  logic              s3_first;
  logic              s3_last;
  logic [DATA_W-1:0] s3_time;
  logic [DATA_W-1:0] max_v;

  // Stage 4: running correction.
  logic              s4_valid;
  logic [DATA_W-1:0] s4_corr;
  logic              s4_last;
  logic [DATA_W-1:0] s4_time;
  logic [DATA_W-1:0] total_correction;
  logic [DATA_W-1:0] total_correction_next;

  // The whole back end moves as one when the output register can take data.
  assign en  = !result_valid || !result_stall;
  assign pop = en && !queue_empty;

  for (genvar j = 0; j < JOINTS; j++) begin : g_sel
    localparam bit IS_LARGE = j < LARGE_JOINTS;
    assign recip_sel[j] = IS_LARGE ? cfg.large_vel_recip : cfg.small_vel_recip;
    assign limit_sel[j] = IS_LARGE ? cfg.large_vel_limit : cfg.small_vel_limit;
  end

  always_comb begin
    max_v = '0;
    for (int j = 0; j < JOINTS; j++) begin
      if (s2_mt[j] > max_v) begin
        max_v = s2_mt[j];
      end
    end
  end

  always_comb begin
    priority if (s3_first) begin
      total_correction_next = '0;
    end else if (s3_invalid) begin
      total_correction_next = sat_add(total_correction, s3_max);
    end else begin
      total_correction_next = total_correction;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      s2_valid         <= 1'b0;
      s3_valid         <= 1'b0;
      s4_valid         <= 1'b0;
      result_valid     <= 1'b0;
      total_correction <= '0;
    end else if (en) begin
      s1_valid     <= pop;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      result_valid <= s4_valid;
      if (s3_valid) begin
        total_correction <= total_correction_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < JOINTS; j++) begin
        s1_mt_prod[j]  <= PROD_W'(head.mag[j]) * PROD_W'(recip_sel[j]);
        s1_lim_prod[j] <= PROD_W'(limit_sel[j]) * PROD_W'(head.planned);
        s2_mt[j]       <= (s1_mt_prod[j][PROD_W-1:48] != '0) ? '1
                                                              : s1_mt_prod[j][47:16];
        s2_exceed[j]   <= s1_pos && ({16'h0, s1_mag[j], 16'h0} > s1_lim_prod[j]);
      end
      s1_mag   <= head.mag;
      s1_pos   <= head.planned_pos;
      s1_first <= head.first;
      s1_last  <= head.last;
      s1_time  <= head.point_time;

      s2_pos   <= s1_pos;
      s2_first <= s1_first;
      s2_last  <= s1_last;
      s2_time  <= s1_time;

      s3_max     <= max_v;
      s3_invalid <= !s2_pos || (|s2_exceed);
      s3_first   <= s2_first;
      s3_last    <= s2_last;
      s3_time    <= s2_time;

      s4_corr <= total_correction_next;
      s4_last <= s3_last;
      s4_time <= s3_time;

      result.fixed_time    <= sat_add(s4_time, s4_corr);
      result.was_corrected <= s4_corr != '0;
      result.is_last       <= s4_last;
    end
  end

`ifndef SYNTHESIS
  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    (en && s3_valid && s3_first) |=> total_correction == '0)
    else $error("first point did not clear the correction");

  a_corr_grows: assert property (@(posedge clk) disable iff (rst)
    (en && s3_valid && !s3_first) |=> total_correction >= $past(total_correction))
    else $error("correction shrank within a trajectory");
`endif

endmodule

// ===== hdl/trajectory_velocity_time_fix_unit.sv =====
// Top level of the trajectory velocity time fix block with its register port.
//
// Points enter on the point channel (point_valid, point_stall, point) and one
// result per point leaves on the result channel (result_valid, result_stall,
// result) in the same order. A transaction completes at a rising clock edge
// where valid is high and stall is low.
// The block sustains one point per clock while the queue is not full. A result
// passes from its accepted point through the segment queue, then the multiply,
// limit test, maximum and correction stages, and the output register.
// Unless the output stalls, throughput is set by the single running add of the
// correction, one segment per cycle; the seven joint lanes work side by side.
// When the receiver stalls, the back end holds and the queue keeps filling at
// the front; point_stall rises only once the queue is full.
// The velocity limits and reciprocals sit on an APB-style port at byte addresses
// 0, 4, 8 and 12 and are written only while the block is idle, which only the user
// enforces, not the block. Synchronous reset empties the pipeline, restores the
// register defaults and clears the previous point and running correction to zero.
module trajectory_velocity_time_fix_unit import tvtf_pkg::*; #(
  parameter int LARGE_JOINTS = LARGE_JOINTS_DEFAULT,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              point_valid,
  output logic              point_stall,
  input  point_t            point,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result
);

  cfg_t       cfg;
  reg_index_t reg_sel;

  logic push;
  seg_t wr_seg;
  seg_t head;
  logic pop;
  logic queue_empty;
  logic queue_full;

  // The register port never waits.
  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.large_vel_limit <= LARGE_VEL_LIMIT_RESET;
      cfg.large_vel_recip <= LARGE_VEL_RECIP_RESET;
      cfg.small_vel_limit <= SMALL_VEL_LIMIT_RESET;
      cfg.small_vel_recip <= SMALL_VEL_RECIP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_LARGE_VEL_LIMIT: cfg.large_vel_limit <= pwdata;
        REG_LARGE_VEL_RECIP: cfg.large_vel_recip <= pwdata;
        REG_SMALL_VEL_LIMIT: cfg.small_vel_limit <= pwdata;
        REG_SMALL_VEL_RECIP: cfg.small_vel_recip <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_LARGE_VEL_LIMIT: prdata = cfg.large_vel_limit;
      REG_LARGE_VEL_RECIP: prdata = cfg.large_vel_recip;
      REG_SMALL_VEL_LIMIT: prdata = cfg.small_vel_limit;
      REG_SMALL_VEL_RECIP: prdata = cfg.small_vel_recip;
      default:             prdata = '0;
    endcase
  end

  // Front end: takes points and turns each into a segment description.
  tvtf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .queue_full  (queue_full),
    .push        (push),
    .seg         (wr_seg)
  );

  // The queue lets the front end keep taking points while the output stalls.
  tvtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_seg (wr_seg),
    .pop    (pop),
    .head   (head),
    .empty  (queue_empty),
    .full   (queue_full)
  );

  // Back end: timing checks, running correction and the output register.
  tvtf_back #(
    .LARGE_JOINTS (LARGE_JOINTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .queue_empty  (queue_empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the trajectory velocity time fix unit.
module testbench import tvtf_pkg::*;;

  // Longest stretch without any accepted transaction before the run is abandoned.
  // The receiver hold-off below is the longest legal quiet stretch.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  // A margin beyond the path from a point through the pipeline to its result.
  localparam int SETTLE_CYCLES  = 12;

  typedef logic [JOINTS-1:0][31:0] joints_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              point_valid;
  logic              point_stall;
  point_t            point;
  logic              result_valid;
  logic              result_stall;
  result_t           result;

  trajectory_velocity_time_fix_unit dut (.*);

  // Local copy of the velocity registers, as the block should hold them.
  logic [31:0] lim_large;
  logic [31:0] recip_large;
  logic [31:0] lim_small;
  logic [31:0] recip_small;

  // Local copy of the segment state: the previous point and the running correction.
  logic [31:0] last_time;
  joints_t     last_pos;
  logic [31:0] correction;

  // Stretched times still owed by the block, oldest first.
  result_t     owed_times[$];
  int          errors = 0;

  // When calm is set, neither side idles at random.
  bit          calm = 1'b0;
  // Asks the receiver process for one long hold-off.
  bit          hold_request = 1'b0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  // State of the trajectory generator.
  joints_t     walk_pos;
  logic [31:0] walk_time;
  bit          walk_open = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Works out the stretched time of one accepted point and advances the
  // local segment state, exactly as the block must.
  function automatic result_t stretch_point(point_t p);
    joints_t     cur;
    longint      planned;
    longint      d;
    logic [63:0] mag;
    logic [63:0] recip;
    logic [63:0] limit;
    logic [63:0] need;
    logic [31:0] slowest;
    bit          too_fast;
    result_t     r;
    cur = {p.pos_6, p.pos_5, p.pos_4, p.pos_3, p.pos_2, p.pos_1, p.pos_0};
    if (p.first_point) begin
      // A new trajectory forgets the correction and evaluates no segment.
      correction = '0;
    end else begin
      planned = longint'({32'b0, p.point_time}) - longint'({32'b0, last_time});
      // A segment that does not move forward in time is always invalid.
      too_fast = (planned <= 0);
      slowest = '0;
      for (int j = 0; j < JOINTS; j++) begin
        d = longint'($signed(cur[j])) - longint'($signed(last_pos[j]));
        mag = (d < 0) ? -d : d;
        if (j < LARGE_JOINTS_DEFAULT) begin
          recip = {32'b0, recip_large};
          limit = {32'b0, lim_large};
        end else begin
          recip = {32'b0, recip_small};
          limit = {32'b0, lim_small};
        end
        need = (mag * recip) >> 16;
        if (need > 64'h0000_0000_FFFF_FFFF) need = 64'h0000_0000_FFFF_FFFF;
        if (planned > 0 && (mag << 16) > limit * 64'(planned)) too_fast = 1'b1;
        if (need[31:0] > slowest) slowest = need[31:0];
      end
      if (too_fast) correction = add_sat(correction, slowest);
    end
    last_time = p.point_time;
    last_pos = cur;
    r.fixed_time = add_sat(p.point_time, correction);
    r.was_corrected = (correction != '0);
    r.is_last = p.last_point;
    return r;
  endfunction

  function automatic point_t make_point(logic [31:0] t, joints_t q, logic first, logic last);
    point_t p;
    p.point_time = t;
    {p.pos_6, p.pos_5, p.pos_4, p.pos_3, p.pos_2, p.pos_1, p.pos_0} = q;
    p.first_point = first;
    p.last_point = last;
    return p;
  endfunction

  function automatic joints_t random_joints();
    joints_t q;
    for (int j = 0; j < JOINTS; j++) q[j] = $urandom;
    return q;
  endfunction

  // Offers one point, waits until the block takes it, and records the stretched
  // time it owes. Called and returns at a falling edge, so valid stays high
  // from one point to the next when no gap is drawn.
  task automatic send_point(point_t p);
    int      gap;
    result_t due;
    if (!calm && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 18);
      point_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_valid = 1'b1;
    point = p;
    do @(posedge clk); while (point_stall);
    due = stretch_point(p);
    owed_times.insert(owed_times.size(), due);
    @(negedge clk);
  endtask

  // Stops offering points and waits until every owed result has come back,
  // then lets the pipeline settle.
  task automatic wait_drained();
    point_valid = 1'b0;
    while (owed_times.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_index_t idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LARGE_VEL_LIMIT: lim_large = value;
      REG_LARGE_VEL_RECIP: recip_large = value;
      REG_SMALL_VEL_LIMIT: lim_small = value;
      REG_SMALL_VEL_RECIP: recip_small = value;
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Registers change only with the block idle.
  task automatic set_rates(logic [31:0] ll, logic [31:0] lr, logic [31:0] sl,
                           logic [31:0] sr);
    wait_drained();
    write_reg(REG_LARGE_VEL_LIMIT, ll);
    write_reg(REG_LARGE_VEL_RECIP, lr);
    write_reg(REG_SMALL_VEL_LIMIT, sl);
    write_reg(REG_SMALL_VEL_RECIP, sr);
  endtask

  // Sends count points, mostly well-formed trajectories: a first point, then
  // points moving forward in time with joint moves near the velocity limit,
  // so that both valid and invalid segments are common. A few points go
  // backward or stand still in time, and a few are pure noise.
  task automatic send_walk(int count);
    point_t      p;
    logic [63:0] reach;
    logic [31:0] span;
    logic [31:0] lim;
    logic [31:0] delta;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        p = make_point($urandom, random_joints(), 1'($urandom), 1'($urandom));
      end else if (pick < 10 || !walk_open) begin
        walk_open = 1'b1;
        walk_time = $urandom_range(0, 32'h0040_0000);
        walk_pos = random_joints();
        p = make_point(walk_time, walk_pos, 1'b1, 1'($urandom_range(0, 99) < 3));
      end else begin
        span = $urandom_range(1, 32'h0002_0000);
        pick = $urandom_range(0, 99);
        // Otherwise the time stands still and the planned time is zero.
        if (pick >= 8) walk_time = walk_time + span;
        else if (pick >= 4) walk_time = walk_time - $urandom_range(1, 32'h0000_8000);
        for (int j = 0; j < JOINTS; j++) begin
          lim = (j < LARGE_JOINTS_DEFAULT) ? lim_large : lim_small;
          reach = ({32'b0, lim} * {32'b0, span}) >> 16;
          if (reach > 64'h1000_0000) reach = 64'h1000_0000;
          // Moves reach a little past the limit now and then.
          delta = $urandom_range(0, reach[31:0] + reach[31:0] / 16 + 1);
          walk_pos[j] = $urandom_range(0, 1) ? walk_pos[j] + delta : walk_pos[j] - delta;
        end
        p = make_point(walk_time, walk_pos, 1'b0, 1'($urandom_range(0, 99) < 4));
      end
      send_point(p);
    end
  endtask

  // Hand-picked points at the reset register values: a segment measured
  // against the reset state, time running backward and standing still,
  // full-scale moves that saturate the correction and the output time, exact
  // limit boundaries on a large and a small joint, and last points followed
  // by a continuing trajectory.
  task automatic test_directed_points();
    joints_t q;
    send_point(make_point(32'h0001_0000, {JOINTS{32'h0000_0100}}, 1'b0, 1'b0));
    send_point(make_point(32'h0000_8000, {JOINTS{32'h0000_0200}}, 1'b0, 1'b0));
    send_point(make_point(32'h0000_0000, {JOINTS{32'h7FFF_FFFF}}, 1'b1, 1'b0));
    send_point(make_point(32'h0001_0000, {JOINTS{32'h8000_0000}}, 1'b0, 1'b0));
    send_point(make_point(32'h0002_0000, {JOINTS{32'h8000_0000}}, 1'b0, 1'b1));
    send_point(make_point(32'h0003_0000, {JOINTS{32'h8000_0000}}, 1'b0, 1'b0));
    send_point(make_point(32'hFFFF_FFFF, '0, 1'b1, 1'b1));
    send_point(make_point(32'hFFFF_FFFF, '0, 1'b0, 1'b0));
    send_point(make_point(32'h0001_0000, '0, 1'b1, 1'b0));
    // One second of planned time: the large joint may move exactly its limit.
    q = '0;
    q[0] = LARGE_VEL_LIMIT_RESET;
    send_point(make_point(32'h0002_0000, q, 1'b0, 1'b0));
    q[0] = q[0] + LARGE_VEL_LIMIT_RESET + 1;
    send_point(make_point(32'h0003_0000, q, 1'b0, 1'b0));
    q[4] = SMALL_VEL_LIMIT_RESET;
    send_point(make_point(32'h0004_0000, q, 1'b0, 1'b0));
    q[4] = q[4] + SMALL_VEL_LIMIT_RESET + 1;
    send_point(make_point(32'h0005_0000, q, 1'b0, 1'b1));
    send_point(make_point(32'hFFFF_0000, q, 1'b0, 1'b0));
    send_point(make_point(32'h1234_5678, {JOINTS{32'hAAAA_AAAA}}, 1'b1, 1'b0));
    send_point(make_point(32'h1234_5679, {JOINTS{32'h5555_5555}}, 1'b0, 1'b1));
  endtask

  // Zero limits and reciprocals, full-scale ones, and a mix of both.
  task automatic test_rate_extremes();
    joints_t q;
    set_rates('0, '0, '0, '0);
    send_point(make_point(32'h0000_0000, '0, 1'b1, 1'b0));
    // A zero limit makes any move invalid, but a zero reciprocal adds nothing.
    q = '0;
    q[1] = 32'h0000_0001;
    send_point(make_point(32'h0001_0000, q, 1'b0, 1'b0));
    send_point(make_point(32'h0002_0000, q, 1'b0, 1'b0));
    set_rates('1, '1, '1, '1);
    send_point(make_point(32'h0000_0000, '0, 1'b1, 1'b0));
    send_point(make_point(32'h0000_0001, {JOINTS{32'h7FFF_FFFF}}, 1'b0, 1'b0));
    set_rates('0, '1, '1, '0);
    send_point(make_point(32'h0000_0000, '0, 1'b1, 1'b0));
    q = '0;
    q[0] = 32'h0001_0000;
    q[5] = 32'h0001_0000;
    send_point(make_point(32'h0001_0000, q, 1'b0, 1'b0));
  endtask

  // Random trajectories under several register settings.
  task automatic test_random_walks();
    set_rates(LARGE_VEL_LIMIT_RESET, LARGE_VEL_RECIP_RESET,
              SMALL_VEL_LIMIT_RESET, SMALL_VEL_RECIP_RESET);
    send_walk(350);
    set_rates($urandom_range(32'h1000, 32'h4_0000), $urandom_range(32'h1000, 32'h10_0000),
              $urandom_range(32'h1000, 32'h4_0000), $urandom_range(32'h1000, 32'h10_0000));
    send_walk(250);
    set_rates($urandom, $urandom, $urandom, $urandom);
    send_walk(150);
    set_rates('0, '0, '0, '0);
    send_walk(100);
    set_rates('1, '1, '1, '1);
    send_walk(100);
    set_rates($urandom_range(32'h1000, 32'h4_0000), $urandom_range(32'h1000, 32'h10_0000),
              $urandom_range(32'h1000, 32'h4_0000), $urandom_range(32'h1000, 32'h10_0000));
    send_walk(250);
    set_rates(LARGE_VEL_LIMIT_RESET, LARGE_VEL_RECIP_RESET,
              SMALL_VEL_LIMIT_RESET, SMALL_VEL_RECIP_RESET);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // points every cycle, so the queue fills and point_stall must rise.
  task automatic test_backpressure();
    wait_drained();
    calm = 1'b1;
    hold_request = 1'b1;
    send_walk(80);
    calm = 1'b0;
  endtask

  // The sender stops mid-trajectory until every result is back, then goes on.
  task automatic test_pause_until_drained();
    send_walk(30);
    wait_drained();
    send_walk(30);
  endtask

  // The last stretch runs at full rate with no idling on either side.
  task automatic test_calm_finish();
    calm = 1'b1;
    send_walk(450);
  endtask

  // Receiver: random stall bursts, the long hold-off on request, and none
  // while calm. Driven at the falling edge like every other input.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall = 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      result_stall = 1'b1;
    end else begin
      result_stall = 1'b0;
    end
  end

  // Each accepted result transaction is checked against the oldest owed time.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (owed_times.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: actual time=%h corrected=%b last=%b",
                 $time, result.fixed_time, result.was_corrected, result.is_last);
      end else begin
        want = owed_times.pop_front();
        if (result.fixed_time !== want.fixed_time ||
            result.was_corrected !== want.was_corrected ||
            result.is_last !== want.is_last) begin
          errors++;
          $display("%0t: mismatch: expected time=%h corrected=%b last=%b, actual time=%h corrected=%b last=%b",
                   $time, want.fixed_time, want.was_corrected, want.is_last,
                   result.fixed_time, result.was_corrected, result.is_last);
        end
      end
    end
  end

  // Watchdog: any accepted transaction on either channel or the register
  // port restarts the count of quiet cycles.
  always @(posedge clk) begin
    if ((point_valid && !point_stall) || (result_valid && !result_stall) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    point_valid = 1'b0;
    point = '0;
    result_stall = 1'b0;
    // The local state starts where reset leaves the block.
    lim_large = LARGE_VEL_LIMIT_RESET;
    recip_large = LARGE_VEL_RECIP_RESET;
    lim_small = SMALL_VEL_LIMIT_RESET;
    recip_small = SMALL_VEL_RECIP_RESET;
    last_time = '0;
    last_pos = '0;
    correction = '0;
    walk_time = '0;
    walk_pos = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_points();
    test_rate_extremes();
    test_random_walks();
    test_backpressure();
    test_pause_until_drained();
    test_calm_finish();
    wait_drained();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tvtf_pkg.sv
hdl/tvtf_front.sv
hdl/tvtf_queue.sv
hdl/tvtf_back.sv
hdl/trajectory_velocity_time_fix_unit.sv
verif/testbench.sv
